FILE: rtl/irpt_pkg.sv
// Shared constants and types for the IR remote power trigger.
// No dependencies; used by ir_remote_power_trigger_top.
package irpt_pkg;

    localparam int PROTO_W   = 8;
    localparam int ADDR_W    = 16;
    localparam int CMD_W     = 16;
    localparam int CODE_W    = PROTO_W + ADDR_W + CMD_W;
    localparam int REPEAT_W  = 8;
    localparam int PRESS_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [PROTO_W-1:0] PROTO_UNTRAINED_LO = 8'h00;
    localparam logic [PROTO_W-1:0] PROTO_UNTRAINED_HI = 8'hFF;
    localparam logic [REPEAT_W-1:0] REPEAT_MAX        = 8'hFF;
    // Third fresh press fires; count holds 0..2 between presses
    localparam logic [PRESS_W-1:0] RESET_LAST_PRESS   = 2'd2;

    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_KEY_CODE = 2'd0,
        CFG_MIN_REPEATS    = 2'd1,
        CFG_FORWARD_ENABLE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic send_report;
        logic forward_code;
        logic press_power;
        logic press_reset;
        logic learned_on;
        logic learned_off;
    } result_t;

    // Protocol byte 0x00 or 0xFF marks a code slot as untrained
    function automatic logic is_untrained(input code_t code);
        logic [PROTO_W-1:0] p;
        p = code[CODE_W-1 -: PROTO_W];
        return (p == PROTO_UNTRAINED_LO) || (p == PROTO_UNTRAINED_HI);
    endfunction

endpackage

FILE: rtl/ir_remote_power_trigger_top.sv
// IR remote power trigger: learning, repeat filter, power and reset presses.
// Depends on irpt_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one decoded IR code per item:
//   protocol_id, device_address, key_command, is_repeat, host_powered.
//   Output channel (out_valid / out_stall) returns exactly one result item
//   per input item: send_report, forward_code, press_power, press_reset,
//   learned_on, learned_off.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   reset_key_code (0), min_repeats (1), forward_enable (2); other indexes
//   are dropped. cfg_ready is always high. Write only while idle.
// Timing:
//   Item goes input register -> decision logic -> result register, and
//   out_valid rises as the result register takes the item. One item per
//   cycle sustained while out_stall is low; the learned codes and counters
//   update in the same cycle the decision is made, so the next item sees
//   them without a bubble.
// Reset: all config, learned codes and counters clear; both codes start
//   untrained, so the first item is learned as power-on and power-off.
// Stall: a held result freezes the result register; an occupied input
//   register then holds too and in_stall stays high until the result is taken.
module ir_remote_power_trigger_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [irpt_pkg::PROTO_W-1:0]  protocol_id,
    input  logic [irpt_pkg::ADDR_W-1:0]   device_address,
    input  logic [irpt_pkg::CMD_W-1:0]    key_command,
    input  logic                          is_repeat,
    input  logic                          host_powered,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          send_report,
    output logic                          forward_code,
    output logic                          press_power,
    output logic                          press_reset,
    output logic                          learned_on,
    output logic                          learned_off,
    // config channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [irpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irpt_pkg::CODE_W-1:0]   cfg_data
);

    // config registers
    irpt_pkg::code_t                 reset_key_reg;
    logic [irpt_pkg::REPEAT_W-1:0]   min_rep_reg;
    logic                            fwd_en_reg;

    // learned codes and counters
    irpt_pkg::code_t                 on_code_reg,  on_code_next;
    irpt_pkg::code_t                 off_code_reg, off_code_next;
    logic [irpt_pkg::REPEAT_W-1:0]   rep_cnt_reg,  rep_cnt_next;
    logic [irpt_pkg::PRESS_W-1:0]    rst_cnt_reg,  rst_cnt_next;

    // input register
    logic                            in_vld_reg;
    irpt_pkg::code_t                 in_code_reg;
    logic                            in_rep_reg;
    logic                            in_host_reg;

    // result register
    logic                            out_vld_reg;
    irpt_pkg::result_t               res_reg, res_next;

    logic                            advance;
    logic                            in_take;
    logic [irpt_pkg::REPEAT_W-1:0]   rep_tmp;

    assign cfg_ready = 1'b1;

    // Input stage moves forward when the result slot is free or draining.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_key_reg <= '0;
            min_rep_reg   <= '0;
            fwd_en_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                irpt_pkg::CFG_RESET_KEY_CODE: reset_key_reg <= cfg_data;
                irpt_pkg::CFG_MIN_REPEATS:    min_rep_reg   <= cfg_data[irpt_pkg::REPEAT_W-1:0];
                irpt_pkg::CFG_FORWARD_ENABLE: fwd_en_reg    <= cfg_data[0];
                default: ;  // unused index
            endcase
        end
    end

    // decision logic
    always_comb
    begin
        on_code_next  = on_code_reg;
        off_code_next = off_code_reg;
        rep_cnt_next  = rep_cnt_reg;
        rst_cnt_next  = rst_cnt_reg;
        res_next      = '0;
        rep_tmp       = '0;

        if (irpt_pkg::is_untrained(on_code_reg))
        begin
            // learning: counter and report path untouched
            on_code_next        = in_code_reg;
            res_next.learned_on = 1'b1;
            if (irpt_pkg::is_untrained(off_code_reg))
            begin
                off_code_next        = in_code_reg;
                res_next.learned_off = 1'b1;
            end
        end
        else
        begin
            // repeat filter, counter saturates then clamps to minimum
            if (!in_rep_reg)
                rep_tmp = '0;
            else if (rep_cnt_reg != irpt_pkg::REPEAT_MAX)
                rep_tmp = rep_cnt_reg + 1'b1;
            else
                rep_tmp = rep_cnt_reg;

            rep_cnt_next = rep_tmp;
            if (rep_tmp >= min_rep_reg)
            begin
                res_next.send_report = 1'b1;
                rep_cnt_next         = min_rep_reg;
            end
            else if (rep_tmp == '0)
                res_next.send_report = 1'b1;

            res_next.forward_code = fwd_en_reg;
            res_next.press_power  = ((in_code_reg == on_code_reg)  && !in_host_reg) ||
                                    ((in_code_reg == off_code_reg) &&  in_host_reg);
        end

        // three fresh reset-code presses in a row
        if (in_code_reg == reset_key_reg)
        begin
            if (!in_rep_reg)
            begin
                if (rst_cnt_reg >= irpt_pkg::RESET_LAST_PRESS)
                begin
                    res_next.press_reset = 1'b1;
                    rst_cnt_next         = '0;
                end
                else
                    rst_cnt_next = rst_cnt_reg + 1'b1;
            end
        end
        else
            rst_cnt_next = '0;
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            on_code_reg  <= '0;
            off_code_reg <= '0;
            rep_cnt_reg  <= '0;
            rst_cnt_reg  <= '0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;

            if (advance)
            begin
                on_code_reg  <= on_code_next;
                off_code_reg <= off_code_next;
                rep_cnt_reg  <= rep_cnt_next;
                rst_cnt_reg  <= rst_cnt_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_code_reg <= {protocol_id, device_address, key_command};
            in_rep_reg  <= is_repeat;
            in_host_reg <= host_powered;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid    = out_vld_reg;
    assign send_report  = res_reg.send_report;
    assign forward_code = res_reg.forward_code;
    assign press_power  = res_reg.press_power;
    assign press_reset  = res_reg.press_reset;
    assign learned_on   = res_reg.learned_on;
    assign learned_off  = res_reg.learned_off;

    // checks
    a_off_implies_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!learned_off || learned_on))
        else $error("learned_off without learned_on");

    a_learn_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && learned_on) |-> (!send_report && !press_power && !forward_code))
        else $error("learning item raised trained-path outputs");

    a_rst_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rst_cnt_reg != 2'd3)
        else $error("reset press count out of range");

    a_rst_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.press_reset) |=> (rst_cnt_reg == '0))
        else $error("reset press did not clear count");

    a_rep_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.send_report && !res_next.learned_on && in_rep_reg)
            |=> (rep_cnt_reg <= $past(min_rep_reg)))
        else $error("repeat count not clamped after report");

endmodule

FILE: test/tb_ir_remote_power_trigger_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ir_remote_power_trigger_top: code learning, repeat
// filter, power and reset presses. Needs irpt_pkg and the block RTL only.
module tb_ir_remote_power_trigger_top;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int TOTAL_ITEMS  = 425;  // directed part plus about 400 random items
    localparam int PHASE_ITEMS  = 35;
    localparam int SATURATE_REPEATS = 258;  // enough to pin the counter at its max
    localparam int LONG_HOLD    = 150;
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 6;    // two-stage pipe, with margin

    localparam logic [irpt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam irpt_pkg::code_t ALL_ZERO_CODE = '0;
    localparam irpt_pkg::code_t ALL_ONES_CODE = '1;
    // The code that ends up trained as both power-on and power-off
    localparam irpt_pkg::code_t TRAINED_CODE  = {8'h5A, 16'h1234, 16'hABCD};

    // Predicts one result per accepted item and checks results in order.
    class power_trigger_scoreboard;
        irpt_pkg::code_t                key_code;
        logic [irpt_pkg::REPEAT_W-1:0]  min_rep;
        logic                           fwd_en;
        irpt_pkg::code_t                on_code;
        irpt_pkg::code_t                off_code;
        logic [irpt_pkg::REPEAT_W-1:0]  rep_cnt;
        logic [irpt_pkg::PRESS_W-1:0]   press_cnt;
        irpt_pkg::result_t              expected_q[$];
        int                             fails;

        function new();
            key_code  = '0;
            min_rep   = '0;
            fwd_en    = 1'b0;
            on_code   = '0;
            off_code  = '0;
            rep_cnt   = '0;
            press_cnt = '0;
            fails     = 0;
        endfunction

        function bit slot_untrained(irpt_pkg::code_t c);
            return c[irpt_pkg::CODE_W-1 -: irpt_pkg::PROTO_W] == irpt_pkg::PROTO_UNTRAINED_LO ||
                   c[irpt_pkg::CODE_W-1 -: irpt_pkg::PROTO_W] == irpt_pkg::PROTO_UNTRAINED_HI;
        endfunction

        function void write_reg(logic [irpt_pkg::CFG_IDX_W-1:0] idx, irpt_pkg::code_t data);
            case (idx)
                irpt_pkg::CFG_RESET_KEY_CODE: key_code = data;
                irpt_pkg::CFG_MIN_REPEATS:    min_rep  = data[irpt_pkg::REPEAT_W-1:0];
                irpt_pkg::CFG_FORWARD_ENABLE: fwd_en   = data[0];
                default: ;
            endcase
        endfunction

        function void note_item(irpt_pkg::code_t code, logic rep, logic host);
            irpt_pkg::result_t r;
            r = '0;
            if (slot_untrained(on_code)) begin
                // learning path: counter untouched, no report / forward / power
                on_code = code;
                r.learned_on = 1'b1;
                if (slot_untrained(off_code)) begin
                    off_code = code;
                    r.learned_off = 1'b1;
                end
            end
            else begin
                if (!rep)
                    rep_cnt = '0;
                else if (rep_cnt != irpt_pkg::REPEAT_MAX)
                    rep_cnt = rep_cnt + 1'b1;
                if (rep_cnt == '0 || rep_cnt >= min_rep) begin
                    r.send_report = 1'b1;
                    if (rep_cnt >= min_rep)
                        rep_cnt = min_rep;
                end
                r.forward_code = fwd_en;
                r.press_power  = (code == on_code && !host) || (code == off_code && host);
            end
            // reset-key run: repeats hold the count, any other code clears it
            if (code == key_code) begin
                if (!rep) begin
                    if (press_cnt == irpt_pkg::RESET_LAST_PRESS) begin
                        r.press_reset = 1'b1;
                        press_cnt = '0;
                    end
                    else
                        press_cnt = press_cnt + 1'b1;
                end
            end
            else
                press_cnt = '0;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want) begin
                $error("%s: expected %0b, got %0b", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(irpt_pkg::result_t got);
            irpt_pkg::result_t want;
            if (expected_q.size() == 0) begin
                $error("result item with no input item outstanding");
                fails++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("send_report",  want.send_report,  got.send_report);
            compare_field("forward_code", want.forward_code, got.forward_code);
            compare_field("press_power",  want.press_power,  got.press_power);
            compare_field("press_reset",  want.press_reset,  got.press_reset);
            compare_field("learned_on",   want.learned_on,   got.learned_on);
            compare_field("learned_off",  want.learned_off,  got.learned_off);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [irpt_pkg::PROTO_W-1:0]    protocol_id;
    logic [irpt_pkg::ADDR_W-1:0]     device_address;
    logic [irpt_pkg::CMD_W-1:0]      key_command;
    logic                            is_repeat;
    logic                            host_powered;
    logic                            out_valid;
    logic                            out_stall;
    logic                            send_report;
    logic                            forward_code;
    logic                            press_power;
    logic                            press_reset;
    logic                            learned_on;
    logic                            learned_off;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [irpt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [irpt_pkg::CODE_W-1:0]     cfg_data;

    power_trigger_scoreboard sb = new();

    bit               tx_burst;       // sender offers back to back
    bit               rx_burst;       // receiver never stalls
    bit               long_hold_req;  // asks the receiver for one long stall
    int               items_sent;
    int               cycle_count = 0;
    irpt_pkg::code_t  cur_key;        // reset key as last written

    ir_remote_power_trigger_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .protocol_id    (protocol_id),
        .device_address (device_address),
        .key_command    (key_command),
        .is_repeat      (is_repeat),
        .host_powered   (host_powered),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .send_report    (send_report),
        .forward_code   (forward_code),
        .press_power    (press_power),
        .press_reset    (press_reset),
        .learned_on     (learned_on),
        .learned_off    (learned_off),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle budget; a hang anywhere ends here as a failure
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_ir_remote_power_trigger_top NOT OK");
        $finish;
    end

    // Result monitor: an item moves when out_valid is high and out_stall low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{send_report, forward_code, press_power,
                              press_reset, learned_on, learned_off});
    end

    // Receiver: random stall before each item, plus one long hold on request
    initial
    begin
        int unsigned gap;
        bit          hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic irpt_pkg::code_t any_code();
        irpt_pkg::code_t c;
        c[irpt_pkg::CODE_W-1 -: irpt_pkg::PROTO_W] = 8'($urandom_range(0, 255));
        c[31:0] = $urandom();
        return c;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_code(input irpt_pkg::code_t c, input logic rep, input logic host);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        {protocol_id, device_address, key_command} <= c;
        is_repeat    <= rep;
        host_powered <= host;
        do @(posedge clk); while (in_stall);
        sb.note_item(c, rep, host);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic config_write(input logic [irpt_pkg::CFG_IDX_W-1:0] idx,
                                input irpt_pkg::code_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all three registers; unused upper data bits carry junk
    task automatic set_filter(input irpt_pkg::code_t key,
                              input logic [irpt_pkg::REPEAT_W-1:0] m, input logic f);
        irpt_pkg::code_t junk;
        junk = any_code();
        config_write(irpt_pkg::CFG_RESET_KEY_CODE, key);
        config_write(irpt_pkg::CFG_MIN_REPEATS,
                     {junk[irpt_pkg::CODE_W-1:irpt_pkg::REPEAT_W], m});
        junk = any_code();
        config_write(irpt_pkg::CFG_FORWARD_ENABLE, {junk[irpt_pkg::CODE_W-1:1], f});
        cur_key = key;
    endtask

    // Stop offering and let every outstanding result come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One fresh press followed by a held key
    task automatic send_hold(input irpt_pkg::code_t c, input int reps);
        send_code(c, 1'b0, rand_bit());
        repeat (reps) send_code(c, 1'b1, rand_bit());
    endtask

    function automatic irpt_pkg::code_t pick_code();
        case ($urandom_range(0, 3))
            0:       return TRAINED_CODE;
            1:       return cur_key;
            default: return any_code();
        endcase
    endfunction

    // Mostly well-formed presses and reset-key runs, some noise
    task automatic random_burst();
        case ($urandom_range(0, 9))
            0: send_code(any_code(), rand_bit(), rand_bit());
            1: begin
                repeat (3) begin
                    send_code(cur_key, 1'b0, rand_bit());
                    if ($urandom_range(0, 2) == 0)
                        send_code(cur_key, 1'b1, rand_bit());
                end
            end
            2: begin
                // run broken by a foreign code
                send_code(cur_key, 1'b0, rand_bit());
                send_code(any_code(), 1'b0, rand_bit());
                send_code(cur_key, 1'b0, rand_bit());
            end
            default: send_hold(pick_code(), $urandom_range(0, 8));
        endcase
    endtask

    initial
    begin
        int phase;
        int phase_end;
        logic [irpt_pkg::REPEAT_W-1:0] m;
        irpt_pkg::code_t key;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        protocol_id    = '0;
        device_address = '0;
        key_command    = '0;
        is_repeat      = 1'b0;
        host_powered   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        long_hold_req  = 1'b0;
        items_sent     = 0;
        cur_key        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Untrained after reset, register defaults. Reset key is the zero code,
        // so the learning items also drive the reset-press count.
        send_code(ALL_ZERO_CODE, 1'b0, 1'b0);
        send_code(ALL_ZERO_CODE, 1'b0, 1'b1);
        send_code(ALL_ZERO_CODE, 1'b1, 1'b0);   // repeat: count holds
        send_code(ALL_ZERO_CODE, 1'b0, 1'b1);   // third fresh press
        send_code(ALL_ONES_CODE, 1'b0, 1'b1);   // protocol 0xFF: still untrained
        send_code(TRAINED_CODE, 1'b1, 1'b0);    // learned, now trained
        // Trained, min_repeats 0: everything reported
        send_code(TRAINED_CODE, 1'b0, 1'b0);    // power press, host off
        send_code(TRAINED_CODE, 1'b1, 1'b1);    // power press, host on
        send_code({8'h00, 16'hFFFF, 16'h0000}, 1'b0, 1'b1);
        send_code({8'hFF, 16'h0000, 16'hFFFF}, 1'b1, 1'b0);

        wait_idle();
        set_filter(ALL_ONES_CODE, 8'd3, 1'b1);
        config_write(CFG_UNUSED_IDX, any_code());   // dropped by the block
        send_code(ALL_ONES_CODE, 1'b0, 1'b0);
        send_code(ALL_ONES_CODE, 1'b1, 1'b1);
        send_code(ALL_ONES_CODE, 1'b1, 1'b0);
        send_code(ALL_ONES_CODE, 1'b0, 1'b1);
        send_code(any_code(), 1'b0, 1'b0);       // breaks the run
        repeat (3) send_code(ALL_ONES_CODE, 1'b0, 1'b1);
        repeat (4) send_code(TRAINED_CODE, 1'b1, 1'b0);  // reaches and clamps at 3

        // Minimum lowered under the held count
        wait_idle();
        set_filter(ALL_ONES_CODE, 8'd1, 1'b0);
        send_code(TRAINED_CODE, 1'b1, 1'b1);

        // Random phases. Phase 0 holds a key past counter saturation with the
        // maximum minimum; phase 1 then opens on a repeat under a newly drawn minimum.
        // Phase 2 runs the long receiver hold with the sender back to back.
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            wait_idle();
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (phase == 0)
                m = irpt_pkg::REPEAT_MAX;
            else
                case ($urandom_range(0, 7))
                    0:       m = '0;
                    7:       m = 8'($urandom_range(0, 255));
                    default: m = 8'($urandom_range(1, 5));
                endcase
            case ($urandom_range(0, 3))
                0:       key = TRAINED_CODE;
                1:       key = any_code();
                2:       key = ALL_ZERO_CODE;
                default: key = ALL_ONES_CODE;
            endcase
            set_filter(key, m, rand_bit());
            if (phase == 1 || $urandom_range(0, 1) == 1)
                send_code(TRAINED_CODE, 1'b1, rand_bit());
            if (phase == 2) begin
                tx_burst = 1'b1;
                long_hold_req = 1'b1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                random_burst();
            if (phase == 0)
                send_hold(TRAINED_CODE, SATURATE_REPEATS);
            phase++;
        end

        wait_idle();
        if (sb.fails == 0)
            $display("tb_ir_remote_power_trigger_top OK");
        else
            $display("tb_ir_remote_power_trigger_top NOT OK");
        $finish;
    end

endmodule
